// ----- sv/frame_time_statistics_macros.svh -----
`ifndef FRAME_TIME_STATISTICS_MACROS_SVH
`define FRAME_TIME_STATISTICS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTS_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- sv/fts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

  localparam int unsigned WINDOW   = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned PosW     = $clog2(WINDOW);
  localparam int unsigned WinShift = $clog2(WINDOW + 1) - 1;
  localparam int unsigned RingSumW = DataW + PosW;
  localparam int unsigned DivCntW  = $clog2(DataW);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_END    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_START   = 2'd0,
    STAT_DONE    = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_EXEC,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic push;
  } ring_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/frame_time_statistics.sv -----
// Frame time statistics monitor.
// The input channel (in_valid_i, in_stall_o) carries one event per transaction:
// a frame start or end with its tick timestamp, or a statistics reset.
// The output channel (out_valid_o, out_stall_i) returns exactly one result
// transaction per event, with the status and the statistics after the event.
// Each event passes through the states S_DIFF and S_EXEC to S_DONE, where
// its result is loaded; for a completed frame, S_DIV_START and S_DIV_WAIT
// come between S_EXEC and S_DONE while a restoring divider computes its
// mean at one quotient bit per cycle. The block takes one event at a time;
// in_stall_o is high from acceptance until the result is loaded.
// A result waits in the output register while out_stall_i is high, and the
// next event may already be taken meanwhile; its result is loaded once the
// waiting one has been taken.
// Reset brings the block to its idle state with all statistics cleared, the
// ring marked empty and no start pending; it needs no clearing sequence.
`timescale 1ns / 1ps
`default_nettype none

module frame_time_statistics (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 opcode_i,
  input  wire logic [fts_pkg::DataW-1:0]  timestamp_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [fts_pkg::DataW-1:0]       last_interval_o,
  output logic [fts_pkg::DataW-1:0]       min_interval_o,
  output logic [fts_pkg::DataW-1:0]       max_interval_o,
  output logic [fts_pkg::DataW-1:0]       mean_interval_o,
  output logic [fts_pkg::DataW-1:0]       window_mean_o,
  output logic [fts_pkg::DataW-1:0]       frames_counted_o
);

  fts_pkg::state_e              state_q, state_d;
  fts_pkg::opcode_e             op_q;
  fts_pkg::status_e             status_q;
  logic [fts_pkg::DataW-1:0]    ts_q;
  logic [fts_pkg::DataW-1:0]    iv_q;
  logic [fts_pkg::DataW-1:0]    start_stamp_q;
  logic                         pending_q;
  logic [fts_pkg::DataW-1:0]    total_q;
  logic [fts_pkg::SumW-1:0]     sum_q;
  logic [fts_pkg::DataW-1:0]    short_q;
  logic [fts_pkg::DataW-1:0]    long_q;
  logic [fts_pkg::DataW-1:0]    latest_q;
  logic [fts_pkg::DataW-1:0]    mean_q;

  logic                         out_valid_q;
  fts_pkg::status_e             out_status_q;
  logic [fts_pkg::DataW-1:0]    out_last_q;
  logic [fts_pkg::DataW-1:0]    out_min_q;
  logic [fts_pkg::DataW-1:0]    out_max_q;
  logic [fts_pkg::DataW-1:0]    out_mean_q;
  logic [fts_pkg::DataW-1:0]    out_win_q;
  logic [fts_pkg::DataW-1:0]    out_count_q;

  logic                         accept;
  logic                         exec;
  logic                         div_start;
  logic                         mean_load;
  logic                         out_load;
  logic                         frame_done;
  logic                         div_done;
  logic [fts_pkg::DataW-1:0]    div_quotient;
  logic [fts_pkg::DataW-1:0]    ring_mean;
  fts_pkg::ring_ctrl_t          ring_ctrl;

  assign in_stall_o = (state_q != fts_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign frame_done = (op_q == fts_pkg::OP_END) && pending_q;

  always_comb begin
    state_d   = state_q;
    exec      = 1'b0;
    div_start = 1'b0;
    mean_load = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      fts_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = fts_pkg::S_DIFF;
        end
      end
      fts_pkg::S_DIFF: begin
        state_d = fts_pkg::S_EXEC;
      end
      fts_pkg::S_EXEC: begin
        exec    = 1'b1;
        state_d = frame_done ? fts_pkg::S_DIV_START : fts_pkg::S_DONE;
      end
      fts_pkg::S_DIV_START: begin
        div_start = 1'b1;
        state_d   = fts_pkg::S_DIV_WAIT;
      end
      fts_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          mean_load = 1'b1;
          state_d   = fts_pkg::S_DONE;
        end
      end
      fts_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = fts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fts_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= fts_pkg::opcode_e'(opcode_i);
      ts_q <= timestamp_i;
    end
    if (state_q == fts_pkg::S_DIFF) begin
      iv_q <= ts_q - start_stamp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_stamp_q <= '0;
      pending_q     <= 1'b0;
      total_q       <= '0;
      sum_q         <= '0;
      short_q       <= '1;
      long_q        <= '0;
      latest_q      <= '0;
      mean_q        <= '0;
      status_q      <= fts_pkg::STAT_IGNORED;
    end else begin
      if (exec) begin
        unique case (op_q)
          fts_pkg::OP_START: begin
            start_stamp_q <= ts_q;
            pending_q     <= 1'b1;
            status_q      <= fts_pkg::STAT_START;
          end
          fts_pkg::OP_END: begin
            if (pending_q) begin
              latest_q  <= iv_q;
              pending_q <= 1'b0;
              status_q  <= fts_pkg::STAT_DONE;
              if (total_q != '1) begin
                total_q <= total_q + 1'b1;
                sum_q   <= sum_q + {{(fts_pkg::SumW - fts_pkg::DataW){1'b0}}, iv_q};
              end
              if (iv_q < short_q) begin
                short_q <= iv_q;
              end
              if (iv_q > long_q) begin
                long_q <= iv_q;
              end
            end else begin
              status_q <= fts_pkg::STAT_IGNORED;
            end
          end
          fts_pkg::OP_CLEAR: begin
            total_q  <= '0;
            sum_q    <= '0;
            short_q  <= '1;
            long_q   <= '0;
            mean_q   <= '0;
            status_q <= fts_pkg::STAT_CLEARED;
          end
          fts_pkg::OP_UNUSED: begin
            status_q <= fts_pkg::STAT_IGNORED;
          end
        endcase
      end
      if (mean_load) begin
        mean_q <= div_quotient;
      end
    end
  end

  assign ring_ctrl.clear = exec && (op_q == fts_pkg::OP_CLEAR);
  assign ring_ctrl.push  = exec && frame_done;

  fts_ring u_ring (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ring_ctrl),
    .value_i       (iv_q),
    .window_mean_o (ring_mean)
  );

  fts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= status_q;
      out_last_q   <= latest_q;
      out_min_q    <= short_q;
      out_max_q    <= long_q;
      out_mean_q   <= mean_q;
      out_win_q    <= ring_mean;
      out_count_q  <= total_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign last_interval_o  = out_last_q;
  assign min_interval_o   = out_min_q;
  assign max_interval_o   = out_max_q;
  assign mean_interval_o  = out_mean_q;
  assign window_mean_o    = out_win_q;
  assign frames_counted_o = out_count_q;

endmodule

`default_nettype wire

// ----- sv/fts_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fts_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [fts_pkg::SumW-1:0]   dividend_i,
  input  wire logic [fts_pkg::DataW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [fts_pkg::DataW-1:0]       quotient_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [fts_pkg::DivCntW-1:0]   cnt_q, cnt_d;
  logic [fts_pkg::DataW-1:0]     rem_q, rem_d;
  logic [fts_pkg::DataW-1:0]     acc_q, acc_d;
  logic [fts_pkg::DataW-1:0]     divisor_q, divisor_d;
  logic [fts_pkg::DataW:0]       trial;
  logic [fts_pkg::DataW:0]       diff;
  logic                          fits;

  // One restoring step per cycle. The upper half of the dividend is always
  // below the divisor, so the quotient fits in DataW bits.
  assign trial = {rem_q, acc_q[fts_pkg::DataW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = ~diff[fts_pkg::DataW];

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    acc_d     = acc_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = '1;
      rem_d     = dividend_i[fts_pkg::SumW-1:fts_pkg::DataW];
      acc_d     = dividend_i[fts_pkg::DataW-1:0];
      divisor_d = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[fts_pkg::DataW-1:0] : trial[fts_pkg::DataW-1:0];
      acc_d = {acc_q[fts_pkg::DataW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    divisor_q <= divisor_d;
  end

  assign done_o     = done_q;
  assign quotient_o = acc_q;

endmodule

`default_nettype wire

// ----- sv/fts_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fts_ring (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fts_pkg::ring_ctrl_t        ctrl_i,
  input  wire logic [fts_pkg::DataW-1:0]  value_i,
  output logic [fts_pkg::DataW-1:0]       window_mean_o
);

  logic [fts_pkg::DataW-1:0]     entry_q [fts_pkg::WINDOW];
  logic [fts_pkg::WINDOW-1:0]    valid_q, valid_d;
  logic [fts_pkg::PosW-1:0]      pos_q, pos_d;
  logic [fts_pkg::RingSumW-1:0]  sum_q, sum_d;
  logic [fts_pkg::DataW-1:0]     old_value;
  logic [fts_pkg::RingSumW-1:0]  shifted;

  // Entries that were never written since the last clear read as zero.
  assign old_value = valid_q[pos_q] ? entry_q[pos_q] : '0;

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    if (ctrl_i.clear) begin
      valid_d = '0;
      pos_d   = '0;
      sum_d   = '0;
    end else if (ctrl_i.push) begin
      valid_d[pos_q] = 1'b1;
      pos_d = (pos_q == fts_pkg::PosW'(fts_pkg::WINDOW - 1)) ? '0 : pos_q + 1'b1;
      sum_d = sum_q
            - {{(fts_pkg::RingSumW - fts_pkg::DataW){1'b0}}, old_value}
            + {{(fts_pkg::RingSumW - fts_pkg::DataW){1'b0}}, value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !ctrl_i.clear) begin
      entry_q[pos_q] <= value_i;
    end
  end

  assign shifted       = sum_q >> fts_pkg::WinShift;
  assign window_mean_o = shifted[fts_pkg::DataW-1:0];

endmodule

`default_nettype wire

// ----- sv/fts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "frame_time_statistics_macros.svh"

module fts_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [1:0]                 status_o,
  input wire logic [fts_pkg::DataW-1:0]  last_interval_o,
  input wire logic [fts_pkg::DataW-1:0]  min_interval_o,
  input wire logic [fts_pkg::DataW-1:0]  max_interval_o,
  input wire logic [fts_pkg::DataW-1:0]  mean_interval_o,
  input wire logic [fts_pkg::DataW-1:0]  window_mean_o,
  input wire logic [fts_pkg::DataW-1:0]  frames_counted_o
);

  logic                          accepted;
  logic                          done_seen;
  logic                          bounds_ok;
  logic                          clear_seen;
  logic                          clear_ok;
  logic                          mean_seen;
  logic                          mean_ok;
  logic                          out_held;
  logic [fts_pkg::DataW+1:0]     out_payload;

  assign accepted   = in_valid_i && !in_stall_o;
  assign done_seen  = out_valid_o && (status_o == fts_pkg::STAT_DONE);
  assign bounds_ok  = (min_interval_o <= last_interval_o)
                   && (last_interval_o <= max_interval_o)
                   && (frames_counted_o != '0);
  assign clear_seen = out_valid_o && (status_o == fts_pkg::STAT_CLEARED);
  assign clear_ok   = (frames_counted_o == '0) && (mean_interval_o == '0)
                   && (max_interval_o == '0) && (min_interval_o == '1)
                   && (window_mean_o == '0);
  assign mean_seen  = out_valid_o && (frames_counted_o != '0);
  assign mean_ok    = (min_interval_o <= mean_interval_o)
                   && (mean_interval_o <= max_interval_o);
  assign out_held    = out_valid_o && out_stall_i;
  assign out_payload = {status_o, last_interval_o};

  // An accepted transaction makes the block busy in the cycle after acceptance.
  `FTS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accepted, in_stall_o)

  // A completed frame lies between the minimum and the maximum, and the frame count is nonzero.
  `FTS_ASSERT_IMPLY(a_frame_bounds, clk_i, rst_ni, done_seen, bounds_ok)

  // A statistics reset reports empty statistics.
  `FTS_ASSERT_IMPLY(a_clear_values, clk_i, rst_ni, clear_seen, clear_ok)

  // The mean lies between the minimum and the maximum once a frame has been counted.
  `FTS_ASSERT_IMPLY(a_mean_bounds, clk_i, rst_ni, mean_seen, mean_ok)

  // A stalled result holds.
  `FTS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_payload))

endmodule

bind frame_time_statistics fts_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 500000;

  typedef logic [fts_pkg::DataW-1:0] word_t;

  class frame_stats_board;
    typedef struct {
      fts_pkg::status_e status;
      word_t            last_iv;
      word_t            min_iv;
      word_t            max_iv;
      word_t            mean_iv;
      word_t            win_mean;
      word_t            count;
    } frame_report_t;

    frame_report_t reports[$];
    int            errors;
    word_t         start_stamp;
    bit            start_pending;
    word_t         frame_total;
    logic [63:0]   interval_sum;
    word_t         shortest;
    word_t         longest;
    word_t         latest;
    word_t         ring[fts_pkg::WINDOW];
    logic [63:0]   ring_sum;
    int unsigned   ring_pos;
    int unsigned   win_shift;

    function new();
      errors        = 0;
      start_stamp   = '0;
      start_pending = 1'b0;
      latest        = '0;
      win_shift     = 0;
      for (int unsigned w = fts_pkg::WINDOW; w > 1; w = w >> 1) win_shift++;
      clear_stats();
    endfunction

    function void clear_stats();
      frame_total  = '0;
      interval_sum = '0;
      shortest     = '1;
      longest      = '0;
      foreach (ring[i]) ring[i] = '0;
      ring_sum     = '0;
      ring_pos     = 0;
    endfunction

    function int waiting();
      return reports.size();
    endfunction

    // Updates the statistics for one accepted transaction and stores the report it must produce.
    function void note_event(fts_pkg::opcode_e op, word_t ts);
      frame_report_t r;
      word_t         iv;
      case (op)
        fts_pkg::OP_START: begin
          start_stamp   = ts;
          start_pending = 1'b1;
          r.status      = fts_pkg::STAT_START;
        end
        fts_pkg::OP_END: begin
          if (start_pending) begin
            iv     = ts - start_stamp;
            latest = iv;
            if (frame_total != '1) begin
              frame_total++;
              interval_sum += {32'd0, iv};
            end
            if (iv < shortest) shortest = iv;
            if (iv > longest) longest = iv;
            ring_sum      = ring_sum - {32'd0, ring[ring_pos]} + {32'd0, iv};
            ring[ring_pos] = iv;
            ring_pos      = (ring_pos + 1) % fts_pkg::WINDOW;
            start_pending = 1'b0;
            r.status      = fts_pkg::STAT_DONE;
          end else begin
            r.status = fts_pkg::STAT_IGNORED;
          end
        end
        fts_pkg::OP_CLEAR: begin
          clear_stats();
          r.status = fts_pkg::STAT_CLEARED;
        end
        default: r.status = fts_pkg::STAT_IGNORED;
      endcase
      r.last_iv  = latest;
      r.min_iv   = shortest;
      r.max_iv   = longest;
      r.mean_iv  = (frame_total != 0) ? word_t'(interval_sum / {32'd0, frame_total}) : '0;
      r.win_mean = word_t'(ring_sum >> win_shift);
      r.count    = frame_total;
      reports.push_back(r);
    endfunction

    function void compare_field(string name, word_t exp_val, word_t act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] status, word_t last_iv, word_t min_iv,
                               word_t max_iv, word_t mean_iv, word_t win_mean, word_t count);
      frame_report_t r;
      if (reports.size() == 0) begin
        $error("unexpected result transaction with status %0d", status);
        errors++;
        return;
      end
      r = reports.pop_front();
      compare_field("status", word_t'(r.status), word_t'(status));
      compare_field("last_interval", r.last_iv, last_iv);
      compare_field("min_interval", r.min_iv, min_iv);
      compare_field("max_interval", r.max_iv, max_iv);
      compare_field("mean_interval", r.mean_iv, mean_iv);
      compare_field("window_mean", r.win_mean, win_mean);
      compare_field("frames_counted", r.count, count);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] opcode_i    = fts_pkg::OP_START;
  word_t      timestamp_i = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  word_t      last_interval_o;
  word_t      min_interval_o;
  word_t      max_interval_o;
  word_t      mean_interval_o;
  word_t      window_mean_o;
  word_t      frames_counted_o;

  frame_stats_board sb;
  bit               calm = 1'b0;
  int               items_sent = 0;
  int               results_seen = 0;
  longint           cycles = 0;

  frame_time_statistics dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .timestamp_i     (timestamp_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .last_interval_o (last_interval_o),
    .min_interval_o  (min_interval_o),
    .max_interval_o  (max_interval_o),
    .mean_interval_o (mean_interval_o),
    .window_mean_o   (window_mean_o),
    .frames_counted_o(frames_counted_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_event(input fts_pkg::opcode_e op, input word_t ts);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    timestamp_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(op, ts);
    if (op != fts_pkg::OP_UNUSED) items_sent++;
    calm = (items_sent >= 300 && items_sent < 400);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
  endtask

  function automatic word_t pick_interval();
    case ($urandom_range(5))
      0:       return $urandom_range(1000);
      1:       return $urandom_range(32'h000F_FFFF);
      2:       return $urandom;
      3:       return '0;
      4:       return '1;
      default: return $urandom_range(60000, 40000);
    endcase
  endfunction

  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, last_interval_o, min_interval_o, max_interval_o,
                        mean_interval_o, window_mean_o, frames_counted_o);
        results_seen++;
        if (results_seen == 100) hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 24);
      end
    end
  end

  initial begin : event_source
    int    pick;
    bit    paused;
    word_t t0;
    word_t t1;
    sb     = new();
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // End with nothing pending, the unused opcode, wrapped and extreme intervals.
    send_event(fts_pkg::OP_END, 32'h0000_1234);
    send_event(fts_pkg::OP_UNUSED, '1);
    send_event(fts_pkg::OP_START, '0);
    send_event(fts_pkg::OP_END, '0);
    send_event(fts_pkg::OP_START, '1);
    send_event(fts_pkg::OP_END, '0);
    send_event(fts_pkg::OP_START, '0);
    send_event(fts_pkg::OP_END, '1);
    // A second start replaces the first timestamp.
    send_event(fts_pkg::OP_START, 32'd100);
    send_event(fts_pkg::OP_START, 32'd5000);
    send_event(fts_pkg::OP_END, 32'd5100);
    send_event(fts_pkg::OP_END, 32'd6000);
    // A statistics reset keeps the pending start.
    send_event(fts_pkg::OP_START, 32'h8000_0000);
    send_event(fts_pkg::OP_CLEAR, 32'h5555_5555);
    send_event(fts_pkg::OP_END, 32'h8000_0010);
    send_event(fts_pkg::OP_CLEAR, 32'hAAAA_AAAA);
    send_event(fts_pkg::OP_END, 32'h0000_0042);
    send_event(fts_pkg::OP_UNUSED, '0);
    drain_results();

    while (items_sent < 600) begin
      if (!paused && items_sent >= 200) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      t0   = $urandom;
      t1   = $urandom;
      if (pick < 70) begin
        send_event(fts_pkg::OP_START, t0);
        send_event(fts_pkg::OP_END, t0 + pick_interval());
      end else if (pick < 78) begin
        send_event(fts_pkg::OP_START, t0);
        send_event(fts_pkg::OP_START, t1);
        send_event(fts_pkg::OP_END, t1 + pick_interval());
      end else if (pick < 86) begin
        send_event(fts_pkg::OP_END, t0);
      end else if (pick < 92) begin
        if ($urandom_range(1)) begin
          send_event(fts_pkg::OP_START, t0);
          send_event(fts_pkg::OP_CLEAR, t1);
          send_event(fts_pkg::OP_END, t0 + pick_interval());
        end else begin
          send_event(fts_pkg::OP_CLEAR, t1);
        end
      end else if (pick < 96) begin
        send_event(fts_pkg::OP_UNUSED, t0);
      end else begin
        send_event(fts_pkg::OP_START, t0);
      end
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
